[rtl/tree_ensemble_inference_top_defines.svh]
// ----------------------------------------------------------------------------
// Tree ensemble inference assertion macros
// Shared property shapes for the checker of the tree ensemble inference block.
// ----------------------------------------------------------------------------
`ifndef TREE_ENSEMBLE_INFERENCE_TOP_DEFINES_SVH
`define TREE_ENSEMBLE_INFERENCE_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TEI_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define TEI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/tei_pkg.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference package
// Shared types, operation codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package tei_pkg;

    // Default sizes of the stores and the walk limit
    localparam int NODE_COUNT_DEF    = 1024;
    localparam int TREE_COUNT_DEF    = 64;
    localparam int FEATURE_COUNT_DEF = 64;
    localparam int WALK_DEPTH_DEF    = 16;

    // Q1.16 probability constants
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_WRITE_NODE    = 2'd0,
        OP_WRITE_ROOT    = 2'd1,
        OP_WRITE_FEATURE = 2'd2,
        OP_CLASSIFY      = 2'd3
    } op_t;

    // Walk sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_FEAT,
        S_CMP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RESULT
    } state_t;

    // One node store entry
    typedef struct packed {
        logic        leaf;
        logic [5:0]  feature;
        logic [31:0] number;
        logic [9:0]  left;
        logic [9:0]  right;
    } node_t;

    // Store write request
    typedef struct packed {
        logic        node_we;
        logic        root_we;
        logic        feat_we;
        logic [9:0]  addr;
        node_t       node;
        logic [9:0]  root;
        logic [31:0] sample;
    } store_wr_t;

endpackage

[rtl/tei_in_if.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference request channel
// Valid/ready channel carrying one write or classify request.
// ----------------------------------------------------------------------------
interface tei_in_if;

    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [9:0]         address;
    logic               node_leaf;
    logic [5:0]         node_feature;
    logic signed [31:0] node_number;
    logic [9:0]         left_child;
    logic [9:0]         right_child;
    logic signed [31:0] sample_value;

    modport source (
        output valid, operation, address, node_leaf, node_feature, node_number,
               left_child, right_child, sample_value,
        input  ready
    );

    modport sink (
        input  valid, operation, address, node_leaf, node_feature, node_number,
               left_child, right_child, sample_value,
        output ready
    );

endinterface

[rtl/tei_out_if.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference result channel
// Valid/ready channel carrying one classification result.
// ----------------------------------------------------------------------------
interface tei_out_if;

    logic        valid;
    logic        ready;
    logic [16:0] probability;
    logic        predicted_class;
    logic        walk_error;

    modport source (
        output valid, probability, predicted_class, walk_error,
        input  ready
    );

    modport sink (
        input  valid, probability, predicted_class, walk_error,
        output ready
    );

endinterface

[rtl/tei_store.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference stores
// Node, root and feature memories: one write port, registered read ports.
// ----------------------------------------------------------------------------
module tei_store #(
    parameter  int NODE_COUNT    = tei_pkg::NODE_COUNT_DEF,
    parameter  int TREE_COUNT    = tei_pkg::TREE_COUNT_DEF,
    parameter  int FEATURE_COUNT = tei_pkg::FEATURE_COUNT_DEF,
    localparam int NODE_AW       = $clog2(NODE_COUNT),
    localparam int ROOT_AW       = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1,
    localparam int FEAT_AW       = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1
) (
    input  logic               clk,
    input  tei_pkg::store_wr_t wr,
    input  logic [NODE_AW-1:0] node_raddr,
    output tei_pkg::node_t     node_rdata,
    input  logic [ROOT_AW-1:0] root_raddr,
    output logic [9:0]         root_rdata,
    input  logic [FEAT_AW-1:0] feat_raddr,
    output logic [31:0]        feat_rdata
);

    tei_pkg::node_t node_mem [NODE_COUNT];
    logic [9:0]     root_mem [TREE_COUNT];
    logic [31:0]    feat_mem [FEATURE_COUNT];

    logic node_hit;
    logic root_hit;
    logic feat_hit;

    // Drop writes beyond the depth of each store
    assign node_hit = 32'(wr.addr) < NODE_COUNT;
    assign root_hit = 32'(wr.addr) < TREE_COUNT;
    assign feat_hit = 32'(wr.addr) < FEATURE_COUNT;

    // Node memory
    always_ff @(posedge clk)
    begin
        if (wr.node_we && node_hit)
        begin
            node_mem[NODE_AW'(wr.addr)] <= wr.node;
        end
        node_rdata <= node_mem[node_raddr];
    end

    // Root memory
    always_ff @(posedge clk)
    begin
        if (wr.root_we && root_hit)
        begin
            root_mem[ROOT_AW'(wr.addr)] <= wr.root;
        end
        root_rdata <= root_mem[root_raddr];
    end

    // Feature memory
    always_ff @(posedge clk)
    begin
        if (wr.feat_we && feat_hit)
        begin
            feat_mem[FEAT_AW'(wr.addr)] <= wr.sample;
        end
        feat_rdata <= feat_mem[feat_raddr];
    end

endmodule

[rtl/tei_divider.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tei_divider #(
    parameter  int NUM_W = 22,
    parameter  int DEN_W = 7,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/tree_ensemble_inference_top.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference top level
// Random-forest binary classifier with node, root and feature stores.
// ----------------------------------------------------------------------------
// Write requests (node, tree root, sample feature) give no result. A classify
// request is accepted, then for each used tree the root is fetched, each split
// node visited takes a feature step and a compare step and the leaf a feature
// step, and a walk that runs too deep is stopped; then the divider takes the
// mean, with NUM_W = 16 + clog2(TREE_COUNT + 1) (23 at the default sizes), and
// the result register is loaded, which waits while an earlier result is still
// held by the sink; with no trees the walks and the mean are skipped. The walk
// sequencer reads the node memory and then the feature memory for each level,
// and the divider produces one quotient bit a cycle. The request channel is not
// ready while a classification runs. The stores come up undefined and need no
// clearing pass; every entry a walk reaches must be written first.
module tree_ensemble_inference_top #(
    parameter int NODE_COUNT    = tei_pkg::NODE_COUNT_DEF,
    parameter int TREE_COUNT    = tei_pkg::TREE_COUNT_DEF,
    parameter int FEATURE_COUNT = tei_pkg::FEATURE_COUNT_DEF,
    parameter int WALK_DEPTH    = tei_pkg::WALK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    tei_in_if.sink     request,
    tei_out_if.source  result
);

    localparam int NODE_AW = $clog2(NODE_COUNT);
    localparam int ROOT_AW = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
    localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CNT_W   = $clog2(TREE_COUNT + 1);
    localparam int SUM_W   = 16 + CNT_W;
    localparam int DEPTH_W = $clog2(WALK_DEPTH + 1);

    tei_pkg::state_t    state_reg;
    tei_pkg::state_t    state_next;
    logic [6:0]         tree_count_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;
    logic [CNT_W-1:0]   t_reg;
    logic [CNT_W-1:0]   t_next;
    logic [9:0]         idx_reg;
    logic [9:0]         idx_next;
    logic [DEPTH_W-1:0] visits_reg;
    logic [DEPTH_W-1:0] visits_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic               err_reg;
    logic               err_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [16:0]        out_prob_reg;
    logic [16:0]        out_prob_next;
    logic               out_class_reg;
    logic               out_class_next;
    logic               out_err_reg;
    logic               out_err_next;

    tei_pkg::store_wr_t wr;
    tei_pkg::node_t     node_rdata;
    tei_pkg::node_t     node_eff;
    logic [9:0]         root_rdata;
    logic [31:0]        feat_rdata;
    logic [31:0]        feat_val;
    logic               accept;
    tei_pkg::op_t       op;
    logic               last_tree;
    logic               go_left;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quotient;

    // Clamp a leaf value into the Q1.16 range
    function automatic logic [16:0] leaf_clamp(input logic [31:0] n);
        logic [16:0] v;
        if ($signed(n) < 0)
        begin
            v = '0;
        end
        else if ($signed(n) > $signed(33'(tei_pkg::ONE_Q16)))
        begin
            v = tei_pkg::ONE_Q16;
        end
        else
        begin
            v = n[16:0];
        end
        return v;
    endfunction

    assign request.ready = (state_reg == tei_pkg::S_IDLE);
    assign accept        = request.valid && request.ready;
    assign op            = tei_pkg::op_t'(request.operation);

    // Route write requests to the stores
    always_comb
    begin
        wr.node_we      = accept && (op == tei_pkg::OP_WRITE_NODE);
        wr.root_we      = accept && (op == tei_pkg::OP_WRITE_ROOT);
        wr.feat_we      = accept && (op == tei_pkg::OP_WRITE_FEATURE);
        wr.addr         = request.address;
        wr.node.leaf    = request.node_leaf;
        wr.node.feature = request.node_feature;
        wr.node.number  = request.node_number;
        wr.node.left    = request.left_child;
        wr.node.right   = request.right_child;
        wr.root         = request.left_child;
        wr.sample       = request.sample_value;
    end

    // Node and root stores read one step ahead so data lines up with the current index
    tei_store #(
        .NODE_COUNT    (NODE_COUNT),
        .TREE_COUNT    (TREE_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_store (
        .clk        (clk),
        .wr         (wr),
        .node_raddr (NODE_AW'(idx_next)),
        .node_rdata (node_rdata),
        .root_raddr (ROOT_AW'(t_next)),
        .root_rdata (root_rdata),
        .feat_raddr (FEAT_AW'(node_rdata.feature)),
        .feat_rdata (feat_rdata)
    );

    // Read out-of-range nodes and features as zero
    assign node_eff  = (32'(idx_reg) < NODE_COUNT) ? node_rdata : '0;
    assign feat_val  = (32'(node_eff.feature) < FEATURE_COUNT) ? feat_rdata : '0;
    assign go_left   = $signed(feat_val) <= $signed(node_eff.number);
    assign last_tree = (t_reg + CNT_W'(1)) == used_reg;

    tei_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (used_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequence the tree walks, the mean and the result
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        visits_next    = visits_reg;
        sum_next       = sum_reg;
        err_next       = err_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg;
        out_prob_next  = out_prob_reg;
        out_class_next = out_class_reg;
        out_err_next   = out_err_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tei_pkg::S_IDLE:
            begin
                if (accept && (op == tei_pkg::OP_CLASSIFY))
                begin
                    used_next = (32'(tree_count_reg) > TREE_COUNT) ?
                                CNT_W'(TREE_COUNT) : CNT_W'(tree_count_reg);
                    t_next    = '0;
                    sum_next  = '0;
                    err_next  = 1'b0;
                    state_next = (used_next == '0) ? tei_pkg::S_RESULT : tei_pkg::S_LOAD;
                end
            end
            tei_pkg::S_LOAD:
            begin
                idx_next    = root_rdata;
                visits_next = '0;
                state_next  = tei_pkg::S_FEAT;
            end
            tei_pkg::S_FEAT:
            begin
                if (node_eff.leaf)
                begin
                    sum_next = sum_reg + SUM_W'(leaf_clamp(node_eff.number));
                    if (last_tree)
                    begin
                        state_next = tei_pkg::S_DIV_GO;
                    end
                    else
                    begin
                        t_next     = t_reg + CNT_W'(1);
                        state_next = tei_pkg::S_LOAD;
                    end
                end
                else
                begin
                    state_next = tei_pkg::S_CMP;
                end
            end
            tei_pkg::S_CMP:
            begin
                if (visits_reg == DEPTH_W'(WALK_DEPTH))
                begin
                    err_next = 1'b1;
                    if (last_tree)
                    begin
                        state_next = tei_pkg::S_DIV_GO;
                    end
                    else
                    begin
                        t_next     = t_reg + CNT_W'(1);
                        state_next = tei_pkg::S_LOAD;
                    end
                end
                else
                begin
                    idx_next    = go_left ? node_eff.left : node_eff.right;
                    visits_next = visits_reg + DEPTH_W'(1);
                    state_next  = tei_pkg::S_FEAT;
                end
            end
            tei_pkg::S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = tei_pkg::S_DIV_WAIT;
            end
            tei_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = tei_pkg::S_RESULT;
                end
            end
            tei_pkg::S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_prob_next  = (used_reg == '0) ? 17'd0 : div_quotient[16:0];
                    out_class_next = out_prob_next > tei_pkg::HALF_Q16;
                    out_err_next   = err_reg;
                    state_next     = tei_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tei_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state and the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tei_pkg::S_IDLE;
            tree_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            used_reg       <= '0;
            t_reg          <= '0;
            idx_reg        <= '0;
            visits_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            t_reg         <= t_next;
            idx_reg       <= idx_next;
            visits_reg    <= visits_next;
            if (cfg_wr_en)
            begin
                tree_count_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the accumulator and the result payload
    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        err_reg       <= err_next;
        out_prob_reg  <= out_prob_next;
        out_class_reg <= out_class_next;
        out_err_reg   <= out_err_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.probability     = out_prob_reg;
    assign result.predicted_class = out_class_reg;
    assign result.walk_error      = out_err_reg;

endmodule

[rtl/tei_checker.sv]
// ----------------------------------------------------------------------------
// Tree ensemble inference checker
// Port-level assertions on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "tree_ensemble_inference_top_defines.svh"

module tei_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_operation,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] out_probability,
    input logic        out_predicted_class,
    input logic        out_walk_error
);

    // A stalled result stays offered
    `TEI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `TEI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_probability) && $stable(out_predicted_class) && $stable(out_walk_error), "result changed while stalled")

    // A classify request blocks the next one
    `TEI_ASSERT_NEXT(a_busy_after_classify, clk, rst_n, in_valid && in_ready && (in_operation == tei_pkg::OP_CLASSIFY), !in_ready, "ready right after a classify request")

    // The class follows the probability, and the probability never exceeds one
    `TEI_ASSERT_SAME(a_class_match, clk, rst_n, out_valid, (out_predicted_class == (out_probability > tei_pkg::HALF_Q16)) && (out_probability <= tei_pkg::ONE_Q16), "class does not match probability")

endmodule

bind tree_ensemble_inference_top tei_checker u_tei_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (request.valid),
    .in_ready            (request.ready),
    .in_operation        (request.operation),
    .out_valid           (result.valid),
    .out_ready           (result.ready),
    .out_probability     (result.probability),
    .out_predicted_class (result.predicted_class),
    .out_walk_error      (result.walk_error)
);
